FILE: src/kdef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_pkg
// Shared types, codes and defaults of the key debounce event fifo.
// ----------------------------------------------------------------------------
package kdef_pkg;

    localparam int DEFAULT_NUM_KEYS   = 4;
    localparam int DEFAULT_FIFO_DEPTH = 16;

    localparam int PIN_W    = 4;
    localparam int KEY_W    = 2;
    localparam int REQ_W    = 2;
    localparam int EV_W     = 2;
    localparam int HOLD_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [EV_W-1:0] EV_LONG    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ENABLE = 2'd2;

    localparam logic [PIN_W-1:0]  PRESS_MASK_RESET  = 4'd0;
    localparam logic [HOLD_W-1:0] LONG_TICKS_RESET  = 16'd100;
    localparam logic              LONG_ENABLE_RESET = 1'b1;

    // request broadcast to every cell
    typedef struct packed {
        logic             tick;
        logic             read;
        logic             clear;
        logic [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        logic [HOLD_W-1:0] ticks;
        logic              enable;
    } cfg_t;

    // result of the item in flight, accumulated cell by cell
    typedef struct packed {
        logic [EV_W-1:0]  code;
        logic [PIN_W-1:0] dropped;
    } chain_t;

endpackage

FILE: src/kdef_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module kdef_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/kdef_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_cell
// One key: debounce state machine, hold counter and its own event ring.
// ----------------------------------------------------------------------------
module kdef_cell
    import kdef_pkg::*;
#(
    parameter int KEY_ID     = 0,
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  cmd_t   cmd,
    input  logic   pressed,
    input  cfg_t   cfg,
    input  chain_t chain_in,
    output chain_t chain_out
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PIN_W-1:0] DROP_BIT =
        (KEY_ID < PIN_W) ? PIN_W'(1 << KEY_ID) : '0;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_TENT = 2'd1;
    localparam logic [1:0] PHASE_HELD = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic              pop_reg, pop_next;
    logic              drop_reg, drop_next;

    logic              mine;
    logic              push;
    logic [EV_W-1:0]   push_ev;
    logic [PTR_W-1:0]  wr_inc;
    logic [PTR_W-1:0]  rd_inc;
    logic              full;
    logic              empty;
    logic              do_write;
    logic              do_pop;
    logic [HOLD_W-1:0] hold_inc;
    logic [EV_W-1:0]   rdata;

    assign mine     = (KEY_ID < (1 << KEY_W)) && (cmd.key == KEY_W'(KEY_ID));
    assign wr_inc   = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
    assign rd_inc   = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
    assign full     = (wr_inc == rd_reg);
    assign empty    = (wr_reg == rd_reg);
    assign hold_inc = (hold_reg == '1) ? hold_reg : hold_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        push       = 1'b0;
        push_ev    = EV_NONE;
        if (cmd.tick)
        begin
            unique case (phase_reg)
                PHASE_IDLE:
                begin
                    if (pressed)
                    begin
                        phase_next = PHASE_TENT;
                        hold_next  = '0;
                    end
                end
                PHASE_TENT:
                begin
                    hold_next = hold_inc;
                    if (pressed)
                    begin
                        push       = 1'b1;
                        push_ev    = EV_PRESS;
                        phase_next = PHASE_HELD;
                    end
                    else
                    begin
                        phase_next = PHASE_IDLE;
                    end
                end
                default:
                begin
                    hold_next = hold_inc;
                    if (!pressed)
                    begin
                        push       = 1'b1;
                        push_ev    = EV_RELEASE;
                        phase_next = PHASE_IDLE;
                    end
                    else if (cfg.enable && (hold_inc >= cfg.ticks))
                    begin
                        push      = 1'b1;
                        push_ev   = EV_LONG;
                        hold_next = '0;
                    end
                end
            endcase
        end
    end

    assign do_write = accept && push && !full;
    assign do_pop   = accept && cmd.read && mine && !empty;

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        pop_next  = pop_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            pop_next  = do_pop;
            drop_next = push && full;
            if (do_write)
            begin
                wr_next = wr_inc;
            end
            if (do_pop)
            begin
                rd_next = rd_inc;
            end
            if (cmd.clear && mine)
            begin
                wr_next = '0;
                rd_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            hold_reg  <= '0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            pop_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                hold_reg  <= hold_next;
            end
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            pop_reg  <= pop_next;
            drop_reg <= drop_next;
        end
    end

    kdef_ram #(
        .WIDTH (EV_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (wr_reg),
        .wdata (push_ev),
        .re    (do_pop),
        .raddr (rd_reg),
        .rdata (rdata)
    );

    // popped data is valid in the cycle after the pop
    always_comb
    begin
        chain_out.code    = chain_in.code | (pop_reg ? rdata : EV_NONE);
        chain_out.dropped = chain_in.dropped | (drop_reg ? DROP_BIT : '0);
    end

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.clear && mine |=> (wr_reg == '0) && (rd_reg == '0))
        else $error("clear left pointers nonzero");

    a_pop_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop_reg && drop_reg))
        else $error("pop and drop on the same item");

    a_tent_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_TENT) |-> (hold_reg == '0))
        else $error("tentative press with nonzero hold count");

endmodule

FILE: src/key_debounce_event_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_fifo
// Per-key push-button debouncer with a per-key event ring.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while in_stall is low. When an item is
// accepted, every key cell updates and the ring read is issued; the popped
// event is then registered into the output register once that register is
// free. The update of the key cells sets the rate; up to two finished
// results are held while the output is stalled before the input stalls.
// Event ring entries carry no reset; pointers and key state reset at once.
module key_debounce_event_fifo
    import kdef_pkg::*;
#(
    parameter int NUM_KEYS   = DEFAULT_NUM_KEYS,
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [PIN_W-1:0]     pin_levels,
    input  logic [KEY_W-1:0]     key_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EV_W-1:0]      event_code,
    output logic [PIN_W-1:0]     instant_pressed,
    output logic [PIN_W-1:0]     dropped_mask,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    logic [PIN_W-1:0]  mask_reg;
    logic [HOLD_W-1:0] ticks_reg;
    logic              enable_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic [PIN_W-1:0]  s1_inst_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic [EV_W-1:0]   s2_code_reg;
    logic [PIN_W-1:0]  s2_inst_reg;
    logic [PIN_W-1:0]  s2_drop_reg;

    logic              accept;
    logic              s2_free;
    logic              s1_adv;
    logic [PIN_W-1:0]  pressed;
    logic [PIN_W-1:0]  inst_next;
    cmd_t              cmd;
    cfg_t              cfg;
    chain_t            chain [NUM_KEYS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= PRESS_MASK_RESET;
            ticks_reg  <= LONG_TICKS_RESET;
            enable_reg <= LONG_ENABLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_PRESS_MASK:  mask_reg   <= wr_data[PIN_W-1:0];
                CFG_LONG_TICKS:  ticks_reg  <= wr_data[HOLD_W-1:0];
                CFG_LONG_ENABLE: enable_reg <= wr_data[0];
                default:         ;
            endcase
        end
    end

    assign s2_free  = !s2_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign accept   = in_valid && !in_stall;

    assign pressed   = ~(pin_levels ^ mask_reg);
    assign inst_next = (req_type == REQ_TICK || req_type == REQ_READ ||
                        req_type == REQ_CLEAR) ? pressed : '0;

    always_comb
    begin
        cmd.tick   = (req_type == REQ_TICK);
        cmd.read   = (req_type == REQ_READ);
        cmd.clear  = (req_type == REQ_CLEAR);
        cmd.key    = key_index;
        cfg.ticks  = ticks_reg;
        cfg.enable = enable_reg;
    end

    assign chain[0] = '0;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_cell
        logic key_pressed;
        if (k < PIN_W)
        begin : g_pin
            assign key_pressed = pressed[k];
        end
        else
        begin : g_nopin
            assign key_pressed = 1'b0;
        end

        kdef_cell #(
            .KEY_ID     (k),
            .FIFO_DEPTH (FIFO_DEPTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (accept),
            .cmd       (cmd),
            .pressed   (key_pressed),
            .cfg       (cfg),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inst_reg <= inst_next;
        end
        if (s1_adv)
        begin
            s2_code_reg <= chain[NUM_KEYS].code;
            s2_inst_reg <= s1_inst_reg;
            s2_drop_reg <= chain[NUM_KEYS].dropped;
        end
    end

    assign out_valid       = s2_valid_reg;
    assign event_code      = s2_code_reg;
    assign instant_pressed = s2_inst_reg;
    assign dropped_mask    = s2_drop_reg;

endmodule

FILE: test/key_debounce_event_fifo_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_test
// Self-checking bench for the per-key debouncer and its event rings. A short
// table of directed items comes first, then random traffic under several
// register settings, checked against a cycle-free prediction of each result.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo_test;
    import kdef_pkg::*;

    localparam int NUM_KEYS      = 4;
    localparam int FIFO_DEPTH    = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLDOFF  = 80;
    localparam int NUM_DIRECTED  = 23;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [1:0] {PH_IDLE, PH_TENT, PH_HELD} key_phase_t;
    typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_EVERY_THIRD} rx_mode_t;

    typedef struct packed {
        logic [EV_W-1:0]  code;
        logic [PIN_W-1:0] pressed;
        logic [PIN_W-1:0] dropped;
    } result_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [PIN_W-1:0] pins;
        logic [KEY_W-1:0] key;
        logic             typed;
        result_t          exp;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type;
    logic [PIN_W-1:0]     pin_levels;
    logic [KEY_W-1:0]     key_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [EV_W-1:0]      event_code;
    logic [PIN_W-1:0]     instant_pressed;
    logic [PIN_W-1:0]     dropped_mask;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    // predicted register and key state
    logic [PIN_W-1:0]  cfg_press_mask;
    logic [HOLD_W-1:0] cfg_long_ticks;
    logic              cfg_long_enable;
    key_phase_t        key_state [NUM_KEYS];
    logic [HOLD_W-1:0] hold_count [NUM_KEYS];
    logic [EV_W-1:0]   event_ring [NUM_KEYS][FIFO_DEPTH];
    logic [3:0]        wr_ptr [NUM_KEYS];
    logic [3:0]        rd_ptr [NUM_KEYS];

    result_t          expected_results [$];
    int               mismatches;
    int               cycle_count;
    int               burst_left;
    bit               holdoff_req;
    logic [PIN_W-1:0] level_state;

    // mask 0 after reset: a key reads pressed while its pin is low
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{REQ_READ,   4'hF, 2'd0, 1'b1, '{EV_NONE,    4'h0, 4'h0}},
        '{REQ_UNUSED, 4'h0, 2'd3, 1'b1, '{EV_NONE,    4'h0, 4'h0}},
        '{REQ_TICK,   4'hF, 2'd0, 1'b1, '{EV_NONE,    4'h0, 4'h0}},
        '{REQ_TICK,   4'h0, 2'd1, 1'b1, '{EV_NONE,    4'hF, 4'h0}},
        '{REQ_TICK,   4'h0, 2'd2, 1'b1, '{EV_NONE,    4'hF, 4'h0}},
        '{REQ_TICK,   4'hA, 2'd3, 1'b1, '{EV_NONE,    4'h5, 4'h0}},
        '{REQ_READ,   4'h0, 2'd0, 1'b1, '{EV_PRESS,   4'hF, 4'h0}},
        '{REQ_READ,   4'hF, 2'd1, 1'b1, '{EV_PRESS,   4'h0, 4'h0}},
        '{REQ_READ,   4'hF, 2'd1, 1'b1, '{EV_RELEASE, 4'h0, 4'h0}},
        '{REQ_READ,   4'hF, 2'd1, 1'b1, '{EV_NONE,    4'h0, 4'h0}},
        '{REQ_CLEAR,  4'h5, 2'd2, 1'b1, '{EV_NONE,    4'hA, 4'h0}},
        '{REQ_READ,   4'h5, 2'd2, 1'b1, '{EV_NONE,    4'hA, 4'h0}},
        '{REQ_TICK,   4'h5, 2'd0, 1'b0, '0},
        '{REQ_TICK,   4'h6, 2'd1, 1'b0, '0},
        '{REQ_TICK,   4'h9, 2'd2, 1'b0, '0},
        '{REQ_READ,   4'h9, 2'd3, 1'b0, '0},
        '{REQ_READ,   4'h0, 2'd0, 1'b0, '0},
        '{REQ_CLEAR,  4'h3, 2'd0, 1'b0, '0},
        '{REQ_UNUSED, 4'hF, 2'd1, 1'b1, '{EV_NONE,    4'h0, 4'h0}},
        '{REQ_TICK,   4'h0, 2'd2, 1'b0, '0},
        '{REQ_TICK,   4'h0, 2'd3, 1'b0, '0},
        '{REQ_READ,   4'hC, 2'd2, 1'b0, '0},
        '{REQ_READ,   4'h3, 2'd3, 1'b0, '0}
    };

    key_debounce_event_fifo #(
        .NUM_KEYS   (NUM_KEYS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .pin_levels      (pin_levels),
        .key_index       (key_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_code      (event_code),
        .instant_pressed (instant_pressed),
        .dropped_mask    (dropped_mask),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic predictor_reset();
        cfg_press_mask  = PRESS_MASK_RESET;
        cfg_long_ticks  = LONG_TICKS_RESET;
        cfg_long_enable = LONG_ENABLE_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_state[k]  = PH_IDLE;
            hold_count[k] = '0;
            wr_ptr[k]     = '0;
            rd_ptr[k]     = '0;
        end
    endtask

    // returns 1 when the ring is full and the event is lost
    function automatic logic ring_push(input int k, input logic [EV_W-1:0] ev);
        logic [3:0] nxt;
        nxt = 4'((wr_ptr[k] + 1) % FIFO_DEPTH);
        if (nxt == rd_ptr[k])
            return 1'b1;
        event_ring[k][wr_ptr[k]] = ev;
        wr_ptr[k] = nxt;
        return 1'b0;
    endfunction

    function automatic result_t debounce_predict(input logic [REQ_W-1:0] req,
                                                 input logic [PIN_W-1:0] pins,
                                                 input logic [KEY_W-1:0] key);
        result_t          r;
        logic [PIN_W-1:0] pressed;
        logic             lost;
        r = '0;
        pressed = ~(pins ^ cfg_press_mask);
        if (req == REQ_UNUSED)
            return r;
        r.pressed = pressed;
        if (req == REQ_TICK)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                lost = 1'b0;
                if (key_state[k] != PH_IDLE && hold_count[k] != 16'hFFFF)
                    hold_count[k] = hold_count[k] + 16'd1;
                case (key_state[k])
                    PH_IDLE:
                    begin
                        if (pressed[k])
                        begin
                            key_state[k]  = PH_TENT;
                            hold_count[k] = '0;
                        end
                    end
                    PH_TENT:
                    begin
                        if (pressed[k])
                        begin
                            lost = ring_push(k, EV_PRESS);
                            key_state[k] = PH_HELD;
                        end
                        else
                            key_state[k] = PH_IDLE;
                    end
                    default:
                    begin
                        if (!pressed[k])
                        begin
                            lost = ring_push(k, EV_RELEASE);
                            key_state[k] = PH_IDLE;
                        end
                        else if (cfg_long_enable && hold_count[k] >= cfg_long_ticks)
                        begin
                            lost = ring_push(k, EV_LONG);
                            hold_count[k] = '0;
                        end
                    end
                endcase
                r.dropped[k] = lost;
            end
        end
        else if (req == REQ_READ)
        begin
            if (rd_ptr[key] != wr_ptr[key])
            begin
                r.code = event_ring[key][rd_ptr[key]];
                rd_ptr[key] = 4'((rd_ptr[key] + 1) % FIFO_DEPTH);
            end
        end
        else
        begin
            wr_ptr[key] = '0;
            rd_ptr[key] = '0;
        end
        return r;
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [PIN_W-1:0] pins,
                             input logic [KEY_W-1:0] key, input logic typed,
                             input result_t row_exp);
        result_t predicted;
        in_valid   <= 1'b1;
        req_type   <= req;
        pin_levels <= pins;
        key_index  <= key;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predicted = debounce_predict(req, pins, key);
        expected_results.push_back(typed ? row_exp : predicted);
    endtask

    // sender bursts with random gaps in between
    task automatic pace();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PRESS_MASK:  cfg_press_mask  = data[PIN_W-1:0];
            CFG_LONG_TICKS:  cfg_long_ticks  = data;
            CFG_LONG_ENABLE: cfg_long_enable = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [PIN_W-1:0] mask, input logic [HOLD_W-1:0] ticks,
                             input logic enable);
        drain(SETTLE_CYCLES);
        write_reg(CFG_PRESS_MASK, {{(CFG_W-PIN_W){1'b0}}, mask});
        write_reg(CFG_LONG_TICKS, ticks);
        write_reg(CFG_LONG_ENABLE, {{(CFG_W-1){1'b0}}, enable});
    endtask

    // mostly slowly changing pin levels so keys get held, some bounce and noise
    task automatic run_traffic(input int items, input int read_pct, input int flip_pct,
                               input bit pressure);
        int               roll;
        logic [PIN_W-1:0] pins;
        for (int n = 0; n < items; n++)
        begin
            pace();
            if (pressure && n == items / 3)
                holdoff_req = 1'b1;
            if (pressure && n == (2 * items) / 3)
                drain(0);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_item(REQ_CLEAR, 4'($urandom), 2'($urandom), 1'b0, '0);
            else if (roll < 5)
                send_item(REQ_UNUSED, 4'($urandom), 2'($urandom), 1'b0, '0);
            else if (roll < 5 + read_pct)
                send_item(REQ_READ, 4'($urandom), 2'($urandom), 1'b0, '0);
            else
            begin
                if ($urandom_range(0, 99) < 8)
                    pins = 4'($urandom);
                else
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                        if ($urandom_range(0, 99) < flip_pct)
                            level_state[k] = ~level_state[k];
                    pins = level_state;
                    // single-tick bounce
                    if ($urandom_range(0, 99) < 5)
                        pins[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
                end
                send_item(REQ_TICK, pins, 2'($urandom), 1'b0, '0);
            end
        end
    endtask

    // receiver stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        rx_mode_t mode;
        int       seg;
        out_stall = 1'b0;
        forever
        begin
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                repeat (LONG_HOLDOFF)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                mode = rx_mode_t'($urandom_range(0, 2));
                seg  = $urandom_range(1, 40);
                for (int i = 0; i < seg; i++)
                begin
                    @(posedge clk);
                    case (mode)
                        RX_FLOW:   out_stall <= 1'b0;
                        RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
                        default:   out_stall <= (i % 3 == 0);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result code %0d pressed %h dropped %h",
                         $time, event_code, instant_pressed, dropped_mask);
                mismatches++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (event_code !== exp.code)
                begin
                    $display("%0t: event_code expected %0d actual %0d",
                             $time, exp.code, event_code);
                    mismatches++;
                end
                if (instant_pressed !== exp.pressed)
                begin
                    $display("%0t: instant_pressed expected %h actual %h",
                             $time, exp.pressed, instant_pressed);
                    mismatches++;
                end
                if (dropped_mask !== exp.dropped)
                begin
                    $display("%0t: dropped_mask expected %h actual %h",
                             $time, exp.dropped, dropped_mask);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_TICK;
        pin_levels  = '0;
        key_index   = '0;
        wr_en       = 1'b0;
        wr_index    = CFG_PRESS_MASK;
        wr_data     = '0;
        mismatches  = 0;
        burst_left  = 0;
        holdoff_req = 1'b0;
        level_state = '0;
        predictor_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            pace();
            send_item(directed_rows[i].req, directed_rows[i].pins, directed_rows[i].key,
                      directed_rows[i].typed, directed_rows[i].exp);
        end

        configure(4'h0, 16'd3, 1'b1);
        run_traffic(150, 30, 20, 1'b0);
        // zero period: long event tried on every held tick, rings overflow
        configure(4'hF, 16'd0, 1'b1);
        run_traffic(120, 5, 10, 1'b0);
        configure(4'($urandom), 16'd1, 1'b0);
        run_traffic(120, 25, 15, 1'b0);
        configure(4'h5, 16'hFFFF, 1'b1);
        run_traffic(120, 35, 25, 1'b0);
        configure(4'($urandom), 16'($urandom_range(2, 10)), 1'b1);
        run_traffic(240, 20, 15, 1'b1);

        drain(2 * SETTLE_CYCLES);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
